>>> rtl/pft_pkg.sv
// Package for the priority fault table: sizes, codes and helpers.
package pft_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned CodeBytes    = 8;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);

  typedef enum logic [2:0] {
    REQ_RAISE     = 3'd0,
    REQ_CLEAR_ONE = 3'd1,
    REQ_CLEAR_TYP = 3'd2,
    REQ_CLEAR_ALL = 3'd3,
    REQ_TOP       = 3'd4,
    REQ_PREFIX    = 3'd5,
    REQ_RSVD6     = 3'd6,
    REQ_RSVD7     = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PFX   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PRESENT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2,
    FSM_OUT  = 2'd3
  } fsm_e;

  localparam int unsigned RegNoneCode   = 0;
  localparam int unsigned RegNoneRating = 1;

  localparam logic [1:0] TypeNone = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] fault_code;
    logic [7:0]  fault_rating;
    logic [1:0]  source_type;
    logic        any_type;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        raised;
    logic        cancelled;
    logic        top_valid;
    logic [1:0]  top_type;
    logic [63:0] top_code;
    logic [7:0]  top_rating;
    logic [4:0]  occupancy;
    logic [4:0]  peak_occupancy;
  } rsp_t;

  // Keep the top CodeBytes bytes up to the first zero byte.
  function automatic logic [63:0] code_form(input logic [63:0] c);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= CodeBytes || c[63-8*i -: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[63-8*i -: 8] = c[63-8*i -: 8];
    end
    return r;
  endfunction

  // Priority from the two-character prefix; valid flag in bit 3.
  function automatic logic [3:0] prio_of(input logic [15:0] p);
    logic [3:0] r;
    unique case (p)
      16'h6269: r = 4'h8;
      16'h4249: r = 4'h9;
      16'h6263: r = 4'hA;
      16'h4243: r = 4'hB;
      16'h6266: r = 4'hC;
      16'h4246: r = 4'hD;
      16'h6265: r = 4'hE;
      16'h4245: r = 4'hF;
      default:  r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pft_if.sv
// Valid/ready channel interfaces for requests and responses.
interface pft_req_if;
  logic            valid;
  logic            ready;
  pft_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pft_rsp_if;
  logic            valid;
  logic            ready;
  pft_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/priority_fault_table_unit.sv
// Priority fault table: top level with sequencer, entry store and APB port.
//
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | req_type, fault_code, fault_rating, source_type, any_type
//  rsp     | out | valid/ready    | status, raised, cancelled, top_*, occupancy, peak
//  apb     | in  | psel/penable   | none_code @0x0, none_rating @0x8
//
// A request is taken only when idle with no response waiting. One slot is visited
// per cycle by a shared compare/rank unit, then come a commit state and a state that
// raises response valid. The next request can be taken the cycle after the response
// transfer, so a new request is taken only once the last response is through; a held
// response holds off the request side for as long.
// Reset empties the table (valid bits cleared); no clearing pass is needed.
module priority_fault_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  pft_req_if.sink            req,
  pft_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned N    = pft_pkg::TableEntries;
  localparam int unsigned IdxW = pft_pkg::IdxW;
  localparam int unsigned CntW = pft_pkg::CntW;

  // ---------------- configuration ----------------
  logic [63:0] none_code_q;
  logic [7:0]  none_rating_q;
  logic        cfg_wr;
  logic [0:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      none_code_q   <= '0;
      none_rating_q <= '0;
    end else if (cfg_wr && paddr[2:0] == 3'd0) begin
      if (cfg_idx == 1'(pft_pkg::RegNoneCode))   none_code_q   <= pwdata;
      if (cfg_idx == 1'(pft_pkg::RegNoneRating)) none_rating_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      if (cfg_idx == 1'(pft_pkg::RegNoneCode))   prdata = none_code_q;
      if (cfg_idx == 1'(pft_pkg::RegNoneRating)) prdata = {{56{none_rating_q[7]}}, none_rating_q};
    end
  end

  // ---------------- entry store ----------------
  logic [N-1:0] valid_q;
  logic [2:0]   prio_q   [N];
  logic [1:0]   type_q   [N];
  logic [63:0]  code_q   [N];
  logic [7:0]   rating_q [N];
  logic [IdxW-1:0] age_q [N];
  logic [CntW-1:0] fill_q, peak_q;

  // ---------------- sequencer ----------------
  pft_pkg::fsm_e   state_q, state_d;
  logic [IdxW-1:0] ptr_q;
  pft_pkg::req_t   rq_q;
  logic [63:0]     cform_q;
  logic [3:0]      pinfo_q;

  // scan results
  logic            dup_q, free_q, hit_q;
  logic [IdxW-1:0] dup_idx_q, free_idx_q, hit_idx_q;
  logic [2:0]      hit_prio_q;
  logic [IdxW-1:0] hit_age_q;
  pft_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q;

  logic            req_acc;
  logic [63:0]     in_cform;

  pft_pkg::req_e   rtype;
  assign rtype = pft_pkg::req_e'(rq_q.req_type);

  assign in_cform = pft_pkg::code_form(req.payload.fault_code);

  // shared per-slot compare unit on slot ptr_q
  logic exact_m, sel_m, better;
  always_comb begin
    exact_m = valid_q[ptr_q] && code_q[ptr_q] == cform_q && type_q[ptr_q] == rq_q.source_type;
    sel_m   = 1'b0;
    if (valid_q[ptr_q]) begin
      if (rtype == pft_pkg::REQ_TOP)
        sel_m = rq_q.any_type || type_q[ptr_q] == rq_q.source_type;
      else if (rtype == pft_pkg::REQ_PREFIX)
        sel_m = type_q[ptr_q] == rq_q.source_type && code_q[ptr_q][63:48] == cform_q[63:48];
    end
    if (prio_q[ptr_q] != hit_prio_q) better = prio_q[ptr_q] > hit_prio_q;
    else                             better = age_q[ptr_q] < hit_age_q;
  end

  assign req.ready   = (state_q == pft_pkg::FSM_IDLE) && !rsp_valid_q;
  assign req_acc     = req.valid && req.ready;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pft_pkg::FSM_IDLE: if (req_acc) state_d = pft_pkg::FSM_SCAN;
      pft_pkg::FSM_SCAN: if (ptr_q == IdxW'(N-1)) state_d = pft_pkg::FSM_DONE;
      pft_pkg::FSM_DONE: state_d = pft_pkg::FSM_OUT;
      pft_pkg::FSM_OUT:  state_d = pft_pkg::FSM_IDLE;
      default:           state_d = pft_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pft_pkg::FSM_IDLE;
    else         state_q <= state_d;
  end

  // Response built from the scan results, latched in the commit cycle.
  always_comb begin
    rsp_d.status         = pft_pkg::ST_OK;
    rsp_d.raised         = 1'b0;
    rsp_d.cancelled      = 1'b0;
    rsp_d.top_valid      = 1'b0;
    rsp_d.top_type       = pft_pkg::TypeNone;
    rsp_d.top_code       = none_code_q;
    rsp_d.top_rating     = none_rating_q;
    rsp_d.occupancy      = 5'(fill_q);
    rsp_d.peak_occupancy = 5'(peak_q);
    unique case (rtype)
      pft_pkg::REQ_RAISE: begin
        if (!pinfo_q[3])  rsp_d.status = pft_pkg::ST_BAD_PFX;
        else if (dup_q)   rsp_d.status = pft_pkg::ST_PRESENT;
        else if (!free_q) rsp_d.status = pft_pkg::ST_FULL;
        else begin
          rsp_d.raised    = 1'b1;
          rsp_d.occupancy = 5'(fill_q + 1'b1);
          if (fill_q + 1'b1 > peak_q) rsp_d.peak_occupancy = 5'(fill_q + 1'b1);
        end
      end
      pft_pkg::REQ_CLEAR_ONE: begin
        if (!dup_q) rsp_d.status = pft_pkg::ST_NOT_FOUND;
        else begin
          rsp_d.occupancy = 5'(fill_q - 1'b1);
          rsp_d.cancelled = 1'b1;
        end
      end
      pft_pkg::REQ_CLEAR_ALL: rsp_d.occupancy = '0;
      pft_pkg::REQ_TOP, pft_pkg::REQ_PREFIX: begin
        if (hit_q) begin
          rsp_d.top_valid  = 1'b1;
          rsp_d.top_type   = type_q[hit_idx_q];
          rsp_d.top_code   = code_q[hit_idx_q];
          rsp_d.top_rating = rating_q[hit_idx_q];
        end
      end
      default: ;
    endcase
  end

  // Drop one slot: close the age ranks above it. Done one slot per scan cycle
  // for clear-type; clear-one drops in the commit cycle.
  logic            drop_now;
  assign drop_now = rtype == pft_pkg::REQ_CLEAR_TYP && valid_q[ptr_q]
                    && type_q[ptr_q] == rq_q.source_type;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fill_q      <= '0;
      peak_q      <= '0;
      rsp_valid_q <= 1'b0;
      ptr_q       <= '0;
    end else begin
      if (state_q == pft_pkg::FSM_OUT)  rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        pft_pkg::FSM_IDLE: begin
          ptr_q <= '0;
          if (req_acc) begin
            rq_q    <= req.payload;
            cform_q <= in_cform;
            pinfo_q <= pft_pkg::prio_of(in_cform[63:48]);
            dup_q   <= 1'b0;
            free_q  <= 1'b0;
            hit_q   <= 1'b0;
            dup_idx_q  <= '0;
            free_idx_q <= '0;
            hit_idx_q  <= '0;
            hit_prio_q <= '0;
            hit_age_q  <= '0;
          end
        end
        pft_pkg::FSM_SCAN: begin
          ptr_q <= ptr_q + 1'b1;
          if (exact_m && !dup_q) begin
            dup_q     <= 1'b1;
            dup_idx_q <= ptr_q;
          end
          if (!valid_q[ptr_q] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= ptr_q;
          end
          if (sel_m && (!hit_q || better)) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= ptr_q;
            hit_prio_q <= prio_q[ptr_q];
            hit_age_q  <= age_q[ptr_q];
          end
          if (drop_now) begin
            for (int j = 0; j < N; j++)
              if (valid_q[j] && age_q[j] > age_q[ptr_q]) age_q[j] <= age_q[j] - 1'b1;
            valid_q[ptr_q] <= 1'b0;
            fill_q <= fill_q - 1'b1;
          end
        end
        pft_pkg::FSM_DONE: begin
          rsp_q <= rsp_d;
          unique case (rtype)
            pft_pkg::REQ_RAISE: begin
              if (pinfo_q[3] && !dup_q && free_q) begin
                valid_q[free_idx_q]  <= 1'b1;
                prio_q[free_idx_q]   <= pinfo_q[2:0];
                type_q[free_idx_q]   <= rq_q.source_type;
                code_q[free_idx_q]   <= cform_q;
                rating_q[free_idx_q] <= rq_q.fault_rating;
                age_q[free_idx_q]    <= IdxW'(fill_q);
                fill_q <= fill_q + 1'b1;
                if (fill_q + 1'b1 > peak_q) peak_q <= fill_q + 1'b1;
              end
            end
            pft_pkg::REQ_CLEAR_ONE: begin
              if (dup_q) begin
                for (int j = 0; j < N; j++)
                  if (valid_q[j] && age_q[j] > age_q[dup_idx_q]) age_q[j] <= age_q[j] - 1'b1;
                valid_q[dup_idx_q] <= 1'b0;
                fill_q <= fill_q - 1'b1;
              end
            end
            pft_pkg::REQ_CLEAR_ALL: begin
              valid_q <= '0;
              fill_q  <= '0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(N)) else $error("fill count overflow");
  // peak never below occupancy
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= fill_q) else $error("peak below fill");
  // fill count matches valid bits while idle
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pft_pkg::FSM_IDLE |-> $countones(valid_q) == int'(fill_q))
    else $error("fill count mismatch");
  // no request accepted while a response waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !req.ready) else $error("accept while response pending");
`endif

endmodule

>>> tb/sv/priority_fault_table_unit_tb.sv
// Self-checking bench for the priority fault table: directed, random and register cases.
`timescale 1ns / 100ps

module priority_fault_table_unit_tb;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  pft_req_if req_ch ();
  pft_rsp_if rsp_ch ();

  priority_fault_table_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the fault table, in slot order.
  logic        shadow_used [pft_pkg::TableEntries];
  logic [2:0]  shadow_prio [pft_pkg::TableEntries];
  logic [1:0]  shadow_type [pft_pkg::TableEntries];
  logic [63:0] shadow_code [pft_pkg::TableEntries];
  logic [7:0]  shadow_rating [pft_pkg::TableEntries];
  int unsigned shadow_age [pft_pkg::TableEntries];
  int unsigned shadow_fill;
  int unsigned shadow_peak;
  logic [63:0] cur_none_code;
  logic [7:0]  cur_none_rating;

  pft_pkg::rsp_t expected_rsp_q [$];
  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_sent;
  bit          stall_hold;   // receiver hold-off request
  bit          allow_gaps;

  localparam logic [15:0] PrefixTab [8] = '{16'h6269, 16'h4249, 16'h6263, 16'h4243,
                                           16'h6266, 16'h4246, 16'h6265, 16'h4245};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout after %0d transfers checked", n_checked);
    $display("priority_fault_table_unit: mismatch");
    $finish;
  end

  // Trim a code to its stored form: ends at the first zero byte.
  function automatic logic [63:0] trim_code(input logic [63:0] c);
    logic [63:0] r;
    bit stop;
    r = '0;
    stop = 0;
    for (int i = 0; i < 8; i++) begin
      if (i >= pft_pkg::CodeBytes || c[63-8*i -: 8] == 8'h00) stop = 1;
      if (!stop) r[63-8*i -: 8] = c[63-8*i -: 8];
    end
    return r;
  endfunction

  function automatic int prio_lookup(input logic [63:0] c);
    for (int i = 0; i < 8; i++)
      if (PrefixTab[i] == c[63:48]) return i;
    return -1;
  endfunction

  function automatic int find_fault(input logic [63:0] c, input logic [1:0] t);
    for (int i = 0; i < pft_pkg::TableEntries; i++)
      if (shadow_used[i] && shadow_code[i] == c && shadow_type[i] == t) return i;
    return -1;
  endfunction

  function automatic void drop_fault(input int s);
    for (int j = 0; j < pft_pkg::TableEntries; j++)
      if (shadow_used[j] && j != s && shadow_age[j] > shadow_age[s]) shadow_age[j]--;
    shadow_used[s] = 1'b0;
    if (shadow_fill > 0) shadow_fill--;
  endfunction

  // Apply one request to the shadow table and return the response it should give.
  function automatic pft_pkg::rsp_t apply_request(input pft_pkg::req_t r);
    pft_pkg::rsp_t o;
    logic [63:0] c;
    int p, s, hit;
    bit m;
    c = trim_code(r.fault_code);
    hit = -1;
    o = '0;
    o.status = pft_pkg::ST_OK;
    case (pft_pkg::req_e'(r.req_type))
      pft_pkg::REQ_RAISE: begin
        p = prio_lookup(c);
        if (p < 0) o.status = pft_pkg::ST_BAD_PFX;
        else if (find_fault(c, r.source_type) >= 0) o.status = pft_pkg::ST_PRESENT;
        else if (shadow_fill >= pft_pkg::TableEntries) o.status = pft_pkg::ST_FULL;
        else begin
          s = -1;
          for (int i = pft_pkg::TableEntries - 1; i >= 0; i--)
            if (!shadow_used[i]) s = i;
          if (s < 0) o.status = pft_pkg::ST_FULL;
          else begin
            shadow_used[s] = 1'b1;
            shadow_prio[s] = p[2:0];
            shadow_type[s] = r.source_type;
            shadow_code[s] = c;
            shadow_rating[s] = r.fault_rating;
            shadow_age[s] = shadow_fill;
            shadow_fill++;
            if (shadow_fill > shadow_peak) shadow_peak = shadow_fill;
            o.raised = 1'b1;
          end
        end
      end
      pft_pkg::REQ_CLEAR_ONE: begin
        s = find_fault(c, r.source_type);
        if (s < 0) o.status = pft_pkg::ST_NOT_FOUND;
        else begin
          drop_fault(s);
          o.cancelled = 1'b1;
        end
      end
      pft_pkg::REQ_CLEAR_TYP: begin
        for (int i = 0; i < pft_pkg::TableEntries; i++)
          if (shadow_used[i] && shadow_type[i] == r.source_type) drop_fault(i);
      end
      pft_pkg::REQ_CLEAR_ALL: begin
        for (int i = 0; i < pft_pkg::TableEntries; i++) shadow_used[i] = 1'b0;
        shadow_fill = 0;
      end
      pft_pkg::REQ_TOP, pft_pkg::REQ_PREFIX: begin
        for (int i = 0; i < pft_pkg::TableEntries; i++) begin
          if (!shadow_used[i]) continue;
          if (r.req_type == pft_pkg::REQ_TOP)
            m = r.any_type || shadow_type[i] == r.source_type;
          else m = shadow_type[i] == r.source_type && shadow_code[i][63:48] == c[63:48];
          // higher priority wins, then the older fault
          if (m && (hit < 0 || shadow_prio[i] > shadow_prio[hit] ||
              (shadow_prio[i] == shadow_prio[hit] && shadow_age[i] < shadow_age[hit])))
            hit = i;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      o.top_valid = 1'b1;
      o.top_type = shadow_type[hit];
      o.top_code = shadow_code[hit];
      o.top_rating = shadow_rating[hit];
    end else begin
      o.top_type = pft_pkg::TypeNone;
      o.top_code = cur_none_code;
      o.top_rating = cur_none_rating;
    end
    o.occupancy = shadow_fill[4:0];
    o.peak_occupancy = shadow_peak[4:0];
    return o;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    if (!allow_gaps) return 0;
    if ($urandom_range(9) < 5) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // Offer one request and wait for its transfer; the expectation is logged at acceptance.
  // Valid is dropped at the transfer edge, so the next offer starts at a later edge.
  task automatic send_request(input pft_pkg::req_t r);
    int unsigned g;
    g = gap_len();
    repeat (g + 1) @(posedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_rsp_q.push_back(apply_request(r));
    n_sent++;
    req_ch.valid <= 1'b0;
  endtask

  function automatic pft_pkg::req_t make_req(input pft_pkg::req_e op, input logic [63:0] c,
                                             input logic [7:0] rt, input logic [1:0] t,
                                             input logic any);
    pft_pkg::req_t r;
    r.req_type = op;
    r.fault_code = c;
    r.fault_rating = rt;
    r.source_type = t;
    r.any_type = any;
    return r;
  endfunction

  // Random code with a valid prefix most of the time; tail may end early.
  function automatic logic [63:0] rand_code(input bit good);
    logic [63:0] c;
    c = {$urandom, $urandom};
    if (good) c[63:48] = PrefixTab[$urandom_range(7)];
    // narrow the tail so repeats (duplicates, clears) actually hit
    if ($urandom_range(3) != 0) c[47:0] = {40'h0, 8'h30 + 8'($urandom_range(3))};
    return c;
  endfunction

  function automatic pft_pkg::req_t rand_req();
    pft_pkg::req_t r;
    int unsigned k;
    k = $urandom_range(99);
    r = make_req(pft_pkg::REQ_RAISE, rand_code($urandom_range(9) != 0), 8'($urandom),
                 2'($urandom_range(3)), 1'($urandom));
    if (k < 45) r.req_type = pft_pkg::REQ_RAISE;
    else if (k < 60) r.req_type = pft_pkg::REQ_CLEAR_ONE;
    else if (k < 64) r.req_type = pft_pkg::REQ_CLEAR_TYP;
    else if (k < 66) r.req_type = pft_pkg::REQ_CLEAR_ALL;
    else if (k < 83) r.req_type = pft_pkg::REQ_TOP;
    else if (k < 97) r.req_type = pft_pkg::REQ_PREFIX;
    else r.req_type = $urandom_range(1) ? pft_pkg::REQ_RSVD6 : pft_pkg::REQ_RSVD7;
    return r;
  endfunction

  task automatic apb_write(input int unsigned idx, input logic [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(8 * idx);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pft_pkg::RegNoneCode) cur_none_code = v;
    else cur_none_rating = v[7:0];
  endtask

  // Configuration may only change once the block has gone quiet.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (expected_rsp_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (pft_pkg::TableEntries + 8) @(posedge clk_i);
  endtask

  // Response side: random back-pressure plus a long hold-off on request.
  initial begin
    int unsigned g;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_hold = 0;
      end
      g = gap_len();
      if (g != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Response checker: every transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    pft_pkg::rsp_t want;
    pft_pkg::rsp_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (expected_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected response %h", got);
      end else begin
        want = expected_rsp_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("response %0d differs: status %0d/%0d raised %0b/%0b cancel %0b/%0b",
                     n_checked, want.status, got.status, want.raised, got.raised,
                     want.cancelled, got.cancelled);
            $display("  top %0b/%0b type %0d/%0d code %h/%h rating %h/%h",
                     want.top_valid, got.top_valid, want.top_type, got.top_type,
                     want.top_code, got.top_code, want.top_rating, got.top_rating);
            $display("  occ %0d/%0d peak %0d/%0d", want.occupancy, got.occupancy,
                     want.peak_occupancy, got.peak_occupancy);
          end
        end
      end
    end
  end

  // Extremes of every field, every request kind and the named corner cases.
  task automatic test_directed();
    allow_gaps = 0;
    send_request(make_req(pft_pkg::REQ_TOP, '1, 8'h80, 2'd0, 1'b1));           // empty table
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h4245_4545_0000_0000, 8'h7F, 2'd0, 1'b0));
    // duplicate after trimming
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h4245_4545_0011_2233, 8'h80, 2'd0, 1'b0));
    // type three
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h4245_4545_0000_0000, 8'h01, 2'd3, 1'b1));
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h6269_FFFF_FFFF_FFFF, 8'h80, 2'd1, 1'b0));
    // bad prefix
    send_request(make_req(pft_pkg::REQ_RAISE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 2'd2, 1'b0));
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h0000_0000_0000_0000, 8'h00, 2'd0, 1'b0));
    send_request(make_req(pft_pkg::REQ_RAISE, 64'h6200_0000_0000_0000, 8'h00, 2'd0, 1'b0));
    send_request(make_req(pft_pkg::REQ_TOP, 64'h0, 8'h0, 2'd3, 1'b0));
    send_request(make_req(pft_pkg::REQ_TOP, 64'h0, 8'h0, 2'd2, 1'b0));
    send_request(make_req(pft_pkg::REQ_PREFIX, 64'h6269_0000_0000_0000, 8'h0, 2'd1, 1'b0));
    send_request(make_req(pft_pkg::REQ_PREFIX, 64'h6269_0000_0000_0000, 8'h0, 2'd0, 1'b0));
    send_request(make_req(pft_pkg::REQ_CLEAR_ONE, 64'h4245_4545_0000_0000, 8'h0, 2'd3, 1'b0));
    // already gone
    send_request(make_req(pft_pkg::REQ_CLEAR_ONE, 64'h4245_4545_0000_0000, 8'h0, 2'd3, 1'b0));
    send_request(make_req(pft_pkg::REQ_RSVD6, '1, 8'hFF, 2'd3, 1'b1));
    send_request(make_req(pft_pkg::REQ_RSVD7, '0, 8'h00, 2'd0, 1'b0));
    // fill to the brim, then more new faults and one duplicate
    for (int i = 0; i < pft_pkg::TableEntries + 1; i++)
      send_request(make_req(pft_pkg::REQ_RAISE, {PrefixTab[i % 8], 8'h41 + 8'(i), 40'h0},
                            8'(i), 2'(i % 3), 1'b0));
    send_request(make_req(pft_pkg::REQ_RAISE, {PrefixTab[0], 8'h41, 40'h0}, 8'h0, 2'd0, 1'b0));
    send_request(make_req(pft_pkg::REQ_TOP, 64'h0, 8'h0, 2'd0, 1'b1));
    send_request(make_req(pft_pkg::REQ_CLEAR_TYP, 64'h0, 8'h0, 2'd1, 1'b0));
    send_request(make_req(pft_pkg::REQ_CLEAR_ALL, 64'h0, 8'h0, 2'd0, 1'b0));
  endtask

  task automatic test_random(input int unsigned count);
    allow_gaps = 1;
    for (int unsigned i = 0; i < count; i++) send_request(rand_req());
  endtask

  // Long receiver hold-off while requests keep coming.
  task automatic test_backpressure();
    stall_hold = 1;
    allow_gaps = 0;
    for (int i = 0; i < 20; i++) send_request(rand_req());
  endtask

  task automatic test_registers(input logic [63:0] nc, input logic [7:0] nr);
    drain();
    apb_write(pft_pkg::RegNoneCode, nc);
    apb_write(pft_pkg::RegNoneRating, {56'h0, nr});
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    n_mismatch = 0;
    n_checked = 0;
    n_sent = 0;
    stall_hold = 0;
    allow_gaps = 0;
    cur_none_code = '0;
    cur_none_rating = '0;
    shadow_fill = 0;
    shadow_peak = 0;
    for (int i = 0; i < pft_pkg::TableEntries; i++) begin
      shadow_used[i] = 1'b0;
      shadow_age[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_registers('1, 8'h7F);
    test_random(130);
    test_backpressure();
    test_registers(64'h0, 8'h80);
    test_random(130);
    test_registers({$urandom, $urandom}, 8'($urandom));
    test_random(130);

    drain();
    if (expected_rsp_q.size() != 0) n_mismatch++;
    $display("sent %0d requests, checked %0d responses across four register settings",
             n_sent, n_checked);
    $display("covered raise/clear/query/prefix, full table, duplicates and a long stall");
    if (n_mismatch == 0) begin
      $display("priority_fault_table_unit: match");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("priority_fault_table_unit: mismatch");
    end
    $finish;
  end

endmodule
